### sv/deq_pkg.sv
// Package for the double-ended queue: sizes, operation and status codes,
// and the command struct shared by the controller and the datapath.
// No dependencies.
package deq_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_BACK  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_BACK   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic load_out;
  } deq_cmd_t;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
    ring_inc = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] idx);
    ring_dec = (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
  endfunction

endpackage

### sv/deq_if.sv
// Handshake interfaces for the request and response channels of the queue.
// Depends on deq_pkg for field widths.
interface deq_req_if;
  import deq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface deq_rsp_if;
  import deq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [CNT_W-1:0]         count;
  logic                     is_empty;
  logic [1:0]               status;

  modport source (output valid, output front_value, output back_value, output count,
                  output is_empty, output status, input ready);
  modport sink (input valid, input front_value, input back_value, input count,
                input is_empty, input status, output ready);
endinterface

### sv/double_ended_queue.sv
// Top level of the double-ended queue: joins the controller and datapath to
// the request and response channels. Depends on deq_pkg, deq_if, deq_ctrl, deq_dp.
//
//   Channel  Dir  Fields                                          Accepted when
//   req_i    in   func, value                                     valid && ready
//   rsp_o    out  front_value, back_value, count, is_empty, status valid && ready
//
// Each item steps through accept, pointer and slot update, RAM read and
// result load; the registered read of the slot RAM needs its own phase.
// The result sits in an output register, so the next item is accepted while
// a result still waits; a stalled response holds the next item in the result
// load phase until the register frees up. Reset clears both pointers, the
// count and the valid flag; slot contents are only read while they hold live
// elements, so the RAM needs no clearing.
module double_ended_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);
  import deq_pkg::*;

  deq_cmd_t cmd;

  // Controller: owns the handshakes and steps each item through its phases.
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // Datapath: ring pointers, occupancy, slot memory and the result register.
  deq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (req_i.func),
    .value_i       (req_i.value),
    .front_value_o (rsp_o.front_value),
    .back_value_o  (rsp_o.back_value),
    .count_o       (rsp_o.count),
    .is_empty_o    (rsp_o.is_empty),
    .status_o      (rsp_o.status)
  );

endmodule

### sv/deq_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                          rdata_a_o,
  output logic [WIDTH-1:0]                          rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### sv/deq_ctrl.sv
// Controller state machine of the queue: sequences accept, update, read and
// response. Depends on deq_pkg.
module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output deq_pkg::deq_cmd_t cmd_o
);
  import deq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    cmd_o          = '0;
    cmd_o.latch_in = in_valid_i && in_ready_o;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a waiting result");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted item not executed next cycle");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

### sv/deq_dp.sv
// Datapath of the queue: ring pointers, occupancy counter, slot RAM and
// result register. Depends on deq_pkg and deq_ram.
module deq_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  deq_pkg::deq_cmd_t                 cmd_i,
  input  logic [1:0]                        func_i,
  input  logic signed [deq_pkg::DATA_W-1:0] value_i,
  output logic signed [deq_pkg::DATA_W-1:0] front_value_o,
  output logic signed [deq_pkg::DATA_W-1:0] back_value_o,
  output logic [deq_pkg::CNT_W-1:0]         count_o,
  output logic                              is_empty_o,
  output logic [1:0]                        status_o
);
  import deq_pkg::*;

  func_e             func_q;
  logic [DATA_W-1:0] value_q;
  logic [IDX_W-1:0]  front_q, front_d, back_q, back_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  status_e           status_q, status_d;
  logic              full, empty;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] rdata_f, rdata_b;
  logic signed [DATA_W-1:0] front_value_q, back_value_q;
  logic [CNT_W-1:0]  count_q;
  status_e           out_status_q;

  assign full  = (occ_q == DEPTH_CNT);
  assign empty = (occ_q == '0);

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    occ_d    = occ_q;
    status_d = ST_OK;
    we       = 1'b0;
    waddr    = back_q;
    unique case (func_q)
      FUNC_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_PUSH_FULL;
        end else begin
          front_d = ring_dec(front_q);
          waddr   = ring_dec(front_q);
          we      = 1'b1;
          occ_d   = occ_q + CNT_W'(1);
        end
      end
      FUNC_PUSH_BACK: begin
        if (full) begin
          status_d = ST_PUSH_FULL;
        end else begin
          waddr  = back_q;
          back_d = ring_inc(back_q);
          we     = 1'b1;
          occ_d  = occ_q + CNT_W'(1);
        end
      end
      FUNC_POP_FRONT: begin
        if (empty) begin
          status_d = ST_POP_EMPTY;
        end else begin
          front_d = ring_inc(front_q);
          occ_d   = occ_q - CNT_W'(1);
        end
      end
      FUNC_POP_BACK: begin
        if (empty) begin
          status_d = ST_POP_EMPTY;
        end else begin
          back_d = ring_dec(back_q);
          occ_d  = occ_q - CNT_W'(1);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.exec && we),
    .waddr_i   (waddr),
    .wdata_i   (value_q),
    .raddr_a_i (front_q),
    .raddr_b_i (ring_dec(back_q)),
    .rdata_a_o (rdata_f),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      back_q   <= '0;
      occ_q    <= '0;
      status_q <= ST_OK;
    end else if (cmd_i.exec) begin
      front_q  <= front_d;
      back_q   <= back_d;
      occ_q    <= occ_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q  <= func_e'(func_i);
      value_q <= value_i;
    end
    if (cmd_i.load_out) begin
      front_value_q <= empty ? '1 : $signed(rdata_f);
      back_value_q  <= empty ? '1 : $signed(rdata_b);
      count_q       <= occ_q;
      out_status_q  <= status_q;
    end
  end

  assign front_value_o = front_value_q;
  assign back_value_o  = back_value_q;
  assign count_o       = count_q;
  assign is_empty_o    = (count_q == '0);
  assign status_o      = out_status_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= DEPTH_CNT)
    else $error("occupancy above depth");

  a_occ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(occ_q))
    else $error("occupancy changed without an update");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> (front_q == back_q))
    else $error("empty queue with split pointers");

endmodule
